FILE: rtl/lcc_pkg.sv
`timescale 1ns / 1ps

package lcc_pkg;

    // field widths fixed by the pixel and table streams
    localparam int CMD_W       = 2;
    localparam int CHAN_W      = 8;
    localparam int CHAN5_W     = 5;
    localparam int TINDEX_W    = 11;
    localparam int TVALUE_W    = 16;
    localparam int LIN_W       = 16;
    localparam int MIX_W       = 16;
    localparam int ROW_W       = 54;
    localparam int CFG_IDX_W   = 2;
    localparam int DG_DEPTH    = 32;
    localparam int DG_IDX_W    = 5;
    localparam int NUM_CHAN    = 3;

    localparam logic [LIN_W-1:0] DEGAMMA_ONE = 16'd32768;

    typedef logic [CMD_W-1:0] t_cmd;

    localparam t_cmd CMD_PIXEL   = 2'd0;
    localparam t_cmd CMD_DEGAMMA = 2'd1;
    localparam t_cmd CMD_ENCODE  = 2'd2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_PASSTHROUGH = 2'd0;
    localparam t_cfg_idx REG_ROW_RED     = 2'd1;
    localparam t_cfg_idx REG_ROW_GREEN   = 2'd2;
    localparam t_cfg_idx REG_ROW_BLUE    = 2'd3;

    // one write into the degamma table copies
    typedef struct packed {
        logic                en;
        logic [DG_IDX_W-1:0] index;
        logic [LIN_W-1:0]    value;
    } t_dg_wr;

    // 5-bit panel value widened to a byte by bit replication
    function automatic logic [CHAN_W-1:0] widen5(input logic [CHAN5_W-1:0] c5);
        widen5 = {c5, c5[CHAN5_W-1:CHAN5_W-3]};
    endfunction

endpackage

FILE: rtl/lcc_ifs.sv
`timescale 1ns / 1ps

interface lcc_pix_in_if;
    import lcc_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [CHAN_W-1:0]   red_in;
    logic [CHAN_W-1:0]   green_in;
    logic [CHAN_W-1:0]   blue_in;
    logic                last_in;
    logic [TINDEX_W-1:0] table_index;
    logic [TVALUE_W-1:0] table_value;

    modport source (
        output valid, command, red_in, green_in, blue_in, last_in, table_index, table_value,
        input  ready
    );
    modport sink (
        input  valid, command, red_in, green_in, blue_in, last_in, table_index, table_value,
        output ready
    );
endinterface

interface lcc_pix_out_if;
    import lcc_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              last_out;

    modport source (
        output valid, red_out, green_out, blue_out, last_out,
        input  ready
    );
    modport sink (
        input  valid, red_out, green_out, blue_out, last_out,
        output ready
    );
endinterface

interface lcc_cfg_if;
    import lcc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [ROW_W-1:0]     data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

FILE: rtl/handheld_lcd_color_correction.sv
`timescale 1ns / 1ps

// Color correction for a handheld LCD pixel stream. Each beat on i_pix is a
// pixel (top five bits of each byte used), a degamma table write (32 entries,
// value saturated to 1.0 in Q1.15) or an encode table write (low byte of the
// value), any other command being dropped; only pixels give a beat on o_pix.
// A pixel goes through degamma, a signed 3x3 matrix, a clamp to [0,2) and
// the encode table, or, in passthrough mode, is widened to 8 bits by bit
// replication. The block takes one beat per clock unless every stage is full
// and the output is stalled. A pixel passes through five register stages:
// input, degamma read, products, sum and clamp, encode read. Each stage
// moves on when the one after it is empty or moving, so bubbles close up
// and a stalled output holds only the stages behind it that are full. Both
// tables are held three times (one copy per channel) so three reads fit in
// a cycle; they are not cleared at reset and must be loaded before pixels
// are sent. Matrix rows reset to the identity, passthrough resets off.
// Configuration writes are always taken and should only happen while no
// pixel is in flight.
module handheld_lcd_color_correction #(
    parameter int ENCODE_INDEX_BITS = 11,
    parameter int COEFF_FRAC_BITS   = 15
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lcc_pix_in_if.sink    i_pix,
    lcc_pix_out_if.source o_pix,
    lcc_cfg_if.sink       i_cfg
);
    import lcc_pkg::*;

    localparam int EIB = ENCODE_INDEX_BITS;
    localparam int CW  = COEFF_FRAC_BITS + 3;

    // identity matrix: 1.0 on the diagonal
    localparam logic [ROW_W-1:0] ID_RED   = ROW_W'(64'd1 << (0 * CW + COEFF_FRAC_BITS));
    localparam logic [ROW_W-1:0] ID_GREEN = ROW_W'(64'd1 << (1 * CW + COEFF_FRAC_BITS));
    localparam logic [ROW_W-1:0] ID_BLUE  = ROW_W'(64'd1 << (2 * CW + COEFF_FRAC_BITS));

    // configuration registers
    logic                                r_passthrough;
    logic [NUM_CHAN-1:0][ROW_W-1:0]      r_row;

    // stage valids and moves
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_en1, w_en2, w_en3, w_en4, w_en5;

    // stage 1: input register
    t_cmd                              r_s1_cmd;
    logic [NUM_CHAN-1:0][CHAN5_W-1:0]  r_s1_rgb5;
    logic                              r_s1_last;
    logic [TINDEX_W-1:0]               r_s1_index;
    logic [TVALUE_W-1:0]               r_s1_value;

    // stages 2 to 4 carry the command and the encode write along
    t_cmd                              r_s2_cmd, r_s3_cmd, r_s4_cmd;
    logic [NUM_CHAN-1:0][CHAN5_W-1:0]  r_s2_rgb5, r_s3_rgb5, r_s4_rgb5, r_s5_rgb5;
    logic                              r_s2_last, r_s3_last, r_s4_last, r_s5_last;
    logic [EIB-1:0]                    r_s2_index, r_s3_index, r_s4_index;
    logic [CHAN_W-1:0]                 r_s2_value, r_s3_value, r_s4_value;

    t_dg_wr                            w_dg_wr;
    logic [NUM_CHAN-1:0][LIN_W-1:0]    w_lin;
    logic [NUM_CHAN-1:0][EIB-1:0]      w_enc_index;
    logic [NUM_CHAN-1:0][CHAN_W-1:0]   w_enc_byte;
    logic                              w_enc_wr;

    // ---------------------------------------------------------------
    // configuration port, always ready
    // ---------------------------------------------------------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_passthrough <= 1'b0;
            r_row[0]      <= ID_RED;
            r_row[1]      <= ID_GREEN;
            r_row[2]      <= ID_BLUE;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_PASSTHROUGH: r_passthrough <= i_cfg.data[0];
                REG_ROW_RED:     r_row[0]      <= i_cfg.data;
                REG_ROW_GREEN:   r_row[1]      <= i_cfg.data;
                REG_ROW_BLUE:    r_row[2]      <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // stage moves: a stage loads when it is empty or its content leaves
    // ---------------------------------------------------------------
    assign w_en5 = !r_v5 || o_pix.ready;
    assign w_en4 = !r_v4 || w_en5;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;

    assign i_pix.ready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_pix.valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
            if (w_en4) begin
                r_v4 <= r_v3;
            end
            // only pixels reach the output stage, table writes end here
            if (w_en5) begin
                r_v5 <= r_v4 && (r_s4_cmd == CMD_PIXEL);
            end
        end
    end

    // ---------------------------------------------------------------
    // stage payloads
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_cmd     <= i_pix.command;
            r_s1_rgb5[0] <= i_pix.red_in[CHAN_W-1 -: CHAN5_W];
            r_s1_rgb5[1] <= i_pix.green_in[CHAN_W-1 -: CHAN5_W];
            r_s1_rgb5[2] <= i_pix.blue_in[CHAN_W-1 -: CHAN5_W];
            r_s1_last    <= i_pix.last_in;
            r_s1_index   <= i_pix.table_index;
            r_s1_value   <= i_pix.table_value;
        end
        if (w_en2) begin
            r_s2_cmd   <= r_s1_cmd;
            r_s2_rgb5  <= r_s1_rgb5;
            r_s2_last  <= r_s1_last;
            r_s2_index <= EIB'(r_s1_index);
            r_s2_value <= r_s1_value[CHAN_W-1:0];
        end
        if (w_en3) begin
            r_s3_cmd   <= r_s2_cmd;
            r_s3_rgb5  <= r_s2_rgb5;
            r_s3_last  <= r_s2_last;
            r_s3_index <= r_s2_index;
            r_s3_value <= r_s2_value;
        end
        if (w_en4) begin
            r_s4_cmd   <= r_s3_cmd;
            r_s4_rgb5  <= r_s3_rgb5;
            r_s4_last  <= r_s3_last;
            r_s4_index <= r_s3_index;
            r_s4_value <= r_s3_value;
        end
        if (w_en5) begin
            r_s5_rgb5 <= r_s4_rgb5;
            r_s5_last <= r_s4_last;
        end
    end

    // ---------------------------------------------------------------
    // degamma: written and read as an item leaves stage 1, so table
    // writes and pixel reads keep stream order
    // ---------------------------------------------------------------
    always_comb begin
        w_dg_wr.en    = r_v1 && w_en2 && (r_s1_cmd == CMD_DEGAMMA);
        w_dg_wr.index = r_s1_index[DG_IDX_W-1:0];
        w_dg_wr.value = (r_s1_value > DEGAMMA_ONE) ? DEGAMMA_ONE : r_s1_value;
    end

    lcc_degamma u_degamma (
        .i_clk     (i_clk),
        .i_wr      (w_dg_wr),
        .i_rd_en   (w_en2),
        .i_rd_addr (r_s1_rgb5),
        .o_lin     (w_lin)
    );

    // products as an item enters stage 3, sum and clamp as it enters stage 4
    lcc_matrix #(
        .ENCODE_INDEX_BITS (ENCODE_INDEX_BITS),
        .COEFF_FRAC_BITS   (COEFF_FRAC_BITS)
    ) u_matrix (
        .i_clk    (i_clk),
        .i_en_mul (w_en3),
        .i_en_sum (w_en4),
        .i_lin    (w_lin),
        .i_row    (r_row),
        .o_index  (w_enc_index)
    );

    // encode: written and read as an item leaves stage 4
    assign w_enc_wr = r_v4 && w_en5 && (r_s4_cmd == CMD_ENCODE);

    lcc_encode #(
        .ENCODE_INDEX_BITS (ENCODE_INDEX_BITS)
    ) u_encode (
        .i_clk      (i_clk),
        .i_wr_en    (w_enc_wr),
        .i_wr_index (r_s4_index),
        .i_wr_value (r_s4_value),
        .i_rd_en    (w_en5),
        .i_rd_index (w_enc_index),
        .o_byte     (w_enc_byte)
    );

    // ---------------------------------------------------------------
    // output beat
    // ---------------------------------------------------------------
    assign o_pix.valid     = r_v5;
    assign o_pix.last_out  = r_s5_last;
    assign o_pix.red_out   = r_passthrough ? widen5(r_s5_rgb5[0]) : w_enc_byte[0];
    assign o_pix.green_out = r_passthrough ? widen5(r_s5_rgb5[1]) : w_enc_byte[1];
    assign o_pix.blue_out  = r_passthrough ? widen5(r_s5_rgb5[2]) : w_enc_byte[2];

`ifndef NO_ASSERTIONS
    // input is held off only when every stage is full
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (r_v1 && r_v2 && r_v3 && r_v4 && r_v5))
        else $error("input stalled with an empty stage");

    // an output beat always comes from a pixel in stage 4
    a_out_from_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_v5) |-> ($past(r_v4) && ($past(r_s4_cmd) == CMD_PIXEL)))
        else $error("output beat without a pixel behind it");

    // a full stage 1 that cannot move keeps its item
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !w_en2) |=> (r_v1 && $stable(r_s1_cmd) && $stable(r_s1_index)))
        else $error("stage 1 item lost while blocked");
`endif

endmodule

FILE: rtl/lcc_degamma.sv
`timescale 1ns / 1ps

module lcc_degamma (
    input  logic                                              i_clk,
    input  lcc_pkg::t_dg_wr                                   i_wr,
    input  logic                                              i_rd_en,
    input  logic [lcc_pkg::NUM_CHAN-1:0][lcc_pkg::DG_IDX_W-1:0] i_rd_addr,
    output logic [lcc_pkg::NUM_CHAN-1:0][lcc_pkg::LIN_W-1:0]    o_lin
);
    import lcc_pkg::*;

    // one copy per channel so each copy has a single read port
    for (genvar c = 0; c < NUM_CHAN; c++) begin : g_copy
        logic [LIN_W-1:0] mem [DG_DEPTH];

        always_ff @(posedge i_clk) begin
            if (i_wr.en) begin
                mem[i_wr.index] <= i_wr.value;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_rd_en) begin
                o_lin[c] <= mem[i_rd_addr[c]];
            end
        end
    end

endmodule

FILE: rtl/lcc_matrix.sv
`timescale 1ns / 1ps

module lcc_matrix #(
    parameter int ENCODE_INDEX_BITS = 11,
    parameter int COEFF_FRAC_BITS   = 15
) (
    input  logic                                            i_clk,
    input  logic                                            i_en_mul,
    input  logic                                            i_en_sum,
    input  logic [lcc_pkg::NUM_CHAN-1:0][lcc_pkg::LIN_W-1:0]  i_lin,
    input  logic [lcc_pkg::NUM_CHAN-1:0][lcc_pkg::ROW_W-1:0]  i_row,
    output logic [lcc_pkg::NUM_CHAN-1:0][ENCODE_INDEX_BITS-1:0] o_index
);
    import lcc_pkg::*;

    localparam int CW    = COEFF_FRAC_BITS + 3;
    localparam int EXT_W = (NUM_CHAN * CW > ROW_W) ? NUM_CHAN * CW : ROW_W;
    localparam int PW    = CW + LIN_W + 1;
    localparam int SW    = PW + 2;
    localparam int QW    = SW - COEFF_FRAC_BITS;

    logic signed [CW-1:0] w_coeff [NUM_CHAN][NUM_CHAN];
    logic signed [PW-1:0] r_prod  [NUM_CHAN][NUM_CHAN];
    logic signed [SW-1:0] w_sum   [NUM_CHAN];
    logic [QW-1:0]        w_quot  [NUM_CHAN];
    logic [MIX_W-1:0]     w_mix   [NUM_CHAN];

    // coefficient fields above the row's stored bits read as zero
    always_comb begin
        for (int o = 0; o < NUM_CHAN; o++) begin
            for (int k = 0; k < NUM_CHAN; k++) begin
                w_coeff[o][k] = signed'(CW'(EXT_W'(i_row[o]) >> (k * CW)));
            end
        end
    end

    // stage one: nine products
    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            for (int o = 0; o < NUM_CHAN; o++) begin
                for (int k = 0; k < NUM_CHAN; k++) begin
                    r_prod[o][k] <= PW'(w_coeff[o][k]) * PW'(signed'({1'b0, i_lin[k]}));
                end
            end
        end
    end

    // stage two: sum, clamp to [0,2), take the top bits as table index
    always_comb begin
        for (int o = 0; o < NUM_CHAN; o++) begin
            w_sum[o]  = SW'(r_prod[o][0]) + SW'(r_prod[o][1]) + SW'(r_prod[o][2]);
            w_quot[o] = w_sum[o][SW-1:COEFF_FRAC_BITS];
            if (w_sum[o][SW-1]) begin
                w_mix[o] = '0;
            end else if (|w_quot[o][QW-1:MIX_W]) begin
                w_mix[o] = '1;
            end else begin
                w_mix[o] = w_quot[o][MIX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_sum) begin
            for (int o = 0; o < NUM_CHAN; o++) begin
                o_index[o] <= w_mix[o][MIX_W-1 -: ENCODE_INDEX_BITS];
            end
        end
    end

endmodule

FILE: rtl/lcc_encode.sv
`timescale 1ns / 1ps

module lcc_encode #(
    parameter int ENCODE_INDEX_BITS = 11
) (
    input  logic                                              i_clk,
    input  logic                                              i_wr_en,
    input  logic [ENCODE_INDEX_BITS-1:0]                      i_wr_index,
    input  logic [lcc_pkg::CHAN_W-1:0]                        i_wr_value,
    input  logic                                              i_rd_en,
    input  logic [lcc_pkg::NUM_CHAN-1:0][ENCODE_INDEX_BITS-1:0] i_rd_index,
    output logic [lcc_pkg::NUM_CHAN-1:0][lcc_pkg::CHAN_W-1:0]   o_byte
);
    import lcc_pkg::*;

    localparam int DEPTH = 1 << ENCODE_INDEX_BITS;

    // one copy per channel, all written together
    for (genvar c = 0; c < NUM_CHAN; c++) begin : g_copy
        logic [CHAN_W-1:0] mem [DEPTH];

        always_ff @(posedge i_clk) begin
            if (i_wr_en) begin
                mem[i_wr_index] <= i_wr_value;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_rd_en) begin
                o_byte[c] <= mem[i_rd_index[c]];
            end
        end
    end

endmodule

FILE: test/handheld_lcd_color_correction_test.sv
`timescale 1ns / 1ps

module handheld_lcd_color_correction_test;
    import lcc_pkg::*;

    // build-time settings of the block under test (its defaults)
    localparam int ENC_BITS   = 11;
    localparam int COEFF_FRAC = 15;
    localparam int COEFF_W    = COEFF_FRAC + 3;
    localparam int ENC_DEPTH  = 1 << ENC_BITS;
    localparam longint MIX_TOP = 65535;

    // five register stages from input beat to output beat
    localparam int PIPE_DEPTH     = 5;
    localparam int SETTLE_CYCLES  = PIPE_DEPTH + 3;
    localparam int RESET_CYCLES   = 5;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 185;

    // the one command code the block must ignore
    localparam t_cmd CMD_UNUSED = 2'd3;

    localparam logic [COEFF_W-1:0] COEFF_ONE = 18'h08000;
    localparam logic [COEFF_W-1:0] COEFF_MAX = 18'h1FFFF;
    localparam logic [COEFF_W-1:0] COEFF_MIN = 18'h20000;

    // one beat on the pixel / table stream
    typedef struct packed {
        t_cmd                cmd;
        logic [CHAN_W-1:0]   red;
        logic [CHAN_W-1:0]   green;
        logic [CHAN_W-1:0]   blue;
        logic                last;
        logic [TINDEX_W-1:0] tidx;
        logic [TVALUE_W-1:0] tval;
    } t_pix_beat;

    // one corrected pixel
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              last;
    } t_pix_rgb;

    // directed rows: a stream beat checked by prediction, a stream beat with
    // its result typed in, or a register write between phases
    typedef enum logic [1:0] {
        STEP_BEAT,
        STEP_TYPED,
        STEP_CFG
    } t_step_kind;

    typedef struct packed {
        t_step_kind       kind;
        t_pix_beat        beat;
        t_cfg_idx         cfg_idx;
        logic [ROW_W-1:0] cfg_data;
        t_pix_rgb         want;
    } t_plan_row;

    // how the matrix rows of a random phase are chosen
    typedef enum logic [2:0] {
        ROWS_IDENTITY,
        ROWS_NEAR,
        ROWS_MAX,
        ROWS_MIN,
        ROWS_ZERO,
        ROWS_RANDOM,
        ROWS_MIXED
    } t_row_style;

    localparam t_pix_beat        NO_BEAT = '0;
    localparam t_pix_rgb         NO_RGB  = '0;
    localparam logic [ROW_W-1:0] NO_DATA = '0;

    localparam int DIR_ROWS = 20;

    localparam t_plan_row DIR_PLAN [DIR_ROWS] = '{
        // passthrough: the widened bytes can be read straight off the input
        '{STEP_CFG, NO_BEAT, REG_PASSTHROUGH, 54'h1, NO_RGB},
        '{STEP_TYPED, '{CMD_PIXEL, 8'h00, 8'h00, 8'h00, 1'b0, 11'h000, 16'h0000},
          REG_PASSTHROUGH, NO_DATA, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{STEP_TYPED, '{CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b1, 11'h7FF, 16'hFFFF},
          REG_PASSTHROUGH, NO_DATA, '{8'hFF, 8'hFF, 8'hFF, 1'b1}},
        '{STEP_TYPED, '{CMD_PIXEL, 8'h80, 8'h40, 8'h08, 1'b0, 11'h000, 16'h0000},
          REG_PASSTHROUGH, NO_DATA, '{8'h84, 8'h42, 8'h08, 1'b0}},
        '{STEP_TYPED, '{CMD_PIXEL, 8'hF7, 8'h07, 8'hA5, 1'b1, 11'h000, 16'h0000},
          REG_PASSTHROUGH, NO_DATA, '{8'hF7, 8'h00, 8'hA5, 1'b1}},
        // unknown command, all fields high: no beat out
        '{STEP_BEAT, '{CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 1'b1, 11'h7FF, 16'hFFFF},
          REG_PASSTHROUGH, NO_DATA, NO_RGB},
        // passthrough off, upper data bits set
        '{STEP_CFG, NO_BEAT, REG_PASSTHROUGH, 54'h3FFFFFFFFFFFFE, NO_RGB},
        // degamma above one saturates, high index bits dropped
        '{STEP_BEAT, '{CMD_DEGAMMA, 8'h00, 8'h00, 8'h00, 1'b0, 11'h7E5, 16'hFFFF},
          REG_PASSTHROUGH, NO_DATA, NO_RGB},
        // encode keeps the low byte only
        '{STEP_BEAT, '{CMD_ENCODE, 8'h00, 8'h00, 8'h00, 1'b0, 11'h7FF, 16'hABCD},
          REG_PASSTHROUGH, NO_DATA, NO_RGB},
        '{STEP_BEAT, '{CMD_DEGAMMA, 8'h00, 8'h00, 8'h00, 1'b0, 11'h01F, 16'h8001},
          REG_PASSTHROUGH, NO_DATA, NO_RGB},
        // identity matrix over the freshly written entries
        '{STEP_BEAT, '{CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b1, 11'h000, 16'h0000},
          REG_PASSTHROUGH, NO_DATA, NO_RGB},
        '{STEP_BEAT, '{CMD_PIXEL, 8'h28, 8'h2F, 8'h2A, 1'b0, 11'h000, 16'h0000},
          REG_PASSTHROUGH, NO_DATA, NO_RGB},
        '{STEP_BEAT, '{CMD_PIXEL, 8'h00, 8'h00, 8'h00, 1'b1, 11'h000, 16'h0000},
          REG_PASSTHROUGH, NO_DATA, NO_RGB},
        // negative sums, saturation above 2.0, most negative coefficients
        '{STEP_CFG, NO_BEAT, REG_ROW_RED, 54'h3FFFFFFFFFFFFF, NO_RGB},
        '{STEP_CFG, NO_BEAT, REG_ROW_GREEN, {3{COEFF_MAX}}, NO_RGB},
        '{STEP_CFG, NO_BEAT, REG_ROW_BLUE, {3{COEFF_MIN}}, NO_RGB},
        '{STEP_BEAT, '{CMD_PIXEL, 8'hFF, 8'h7F, 8'h80, 1'b1, 11'h000, 16'h0000},
          REG_PASSTHROUGH, NO_DATA, NO_RGB},
        '{STEP_BEAT, '{CMD_PIXEL, 8'h28, 8'h28, 8'h28, 1'b0, 11'h000, 16'h0000},
          REG_PASSTHROUGH, NO_DATA, NO_RGB},
        // all-zero row lands on encode entry zero
        '{STEP_CFG, NO_BEAT, REG_ROW_RED, NO_DATA, NO_RGB},
        '{STEP_BEAT, '{CMD_PIXEL, 8'h10, 8'h20, 8'h30, 1'b1, 11'h000, 16'h0000},
          REG_PASSTHROUGH, NO_DATA, NO_RGB}
    };

    localparam t_row_style PHASE_STYLE [PHASES] = '{
        ROWS_IDENTITY, ROWS_NEAR, ROWS_MAX, ROWS_NEAR,
        ROWS_RANDOM, ROWS_MIN, ROWS_ZERO, ROWS_MIXED
    };
    localparam int BYPASS_PHASE = 3;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lcc_pix_in_if  pix_in ();
    lcc_pix_out_if pix_out ();
    lcc_cfg_if     cfg ();

    handheld_lcd_color_correction dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in),
        .o_pix   (pix_out),
        .i_cfg   (cfg)
    );

    always #10 i_clk = ~i_clk;

    // predictor state: tables, passthrough flag and matrix rows as the block holds them
    logic [LIN_W-1:0]  lin_lut [DG_DEPTH];
    logic [CHAN_W-1:0] enc_lut [ENC_DEPTH];
    logic              bypass_on = 1'b0;
    logic [ROW_W-1:0]  mix_rows [NUM_CHAN] = '{
        {18'h0, 18'h0, COEFF_ONE},
        {18'h0, COEFF_ONE, 18'h0},
        {COEFF_ONE, 18'h0, 18'h0}
    };

    // corrected pixels still owed by the block, oldest first
    t_pix_rgb pending_rgb [$];

    int  err_count    = 0;
    int  quiet_cycles = 0;
    int  stall_left   = 0;
    bit  tx_calm      = 1'b0;
    bit  rx_calm      = 1'b0;

    // idle length: mostly none, often a few cycles, now and then a long one
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // one output byte: signed mix of the linear values, clamp to [0,2), encode lookup
    function automatic logic [CHAN_W-1:0] mix_lane(input logic [ROW_W-1:0] row,
                                                   input logic [2:0][LIN_W-1:0] lin);
        longint                    acc;
        longint                    level;
        logic signed [COEFF_W-1:0] coeff;
        acc = 0;
        for (int k = 0; k < NUM_CHAN; k++) begin
            coeff = row[k*COEFF_W +: COEFF_W];
            acc += longint'(coeff) * longint'(lin[k]);
        end
        // negative light clamps to zero and reads encode entry zero
        if (acc < 0)
            return enc_lut[0];
        level = acc >>> COEFF_FRAC;
        if (level > MIX_TOP)
            level = MIX_TOP;
        return enc_lut[level[MIX_W-1 -: ENC_BITS]];
    endfunction

    // applies one accepted beat to the predictor; returns 1 when a pixel comes out
    function automatic bit correct_beat(input t_pix_beat b, output t_pix_rgb res);
        logic [2:0][CHAN5_W-1:0] c5;
        logic [2:0][LIN_W-1:0]   lin;
        logic [2:0][CHAN_W-1:0]  outb;
        res = '0;
        c5  = {b.blue[7:3], b.green[7:3], b.red[7:3]};
        case (b.cmd)
            CMD_DEGAMMA: begin
                lin_lut[b.tidx[DG_IDX_W-1:0]] = (b.tval > DEGAMMA_ONE) ? DEGAMMA_ONE : b.tval;
                return 1'b0;
            end
            CMD_ENCODE: begin
                enc_lut[b.tidx[ENC_BITS-1:0]] = b.tval[7:0];
                return 1'b0;
            end
            CMD_PIXEL: begin
                for (int k = 0; k < NUM_CHAN; k++)
                    lin[k] = lin_lut[c5[k]];
                for (int k = 0; k < NUM_CHAN; k++) begin
                    if (bypass_on)
                        outb[k] = {c5[k], 3'b000} | CHAN_W'(c5[k] >> 2);
                    else
                        outb[k] = mix_lane(mix_rows[k], lin);
                end
                res = '{outb[0], outb[1], outb[2], b.last};
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic void store_reg(input t_cfg_idx idx, input logic [ROW_W-1:0] data);
        case (idx)
            REG_PASSTHROUGH: bypass_on   = data[0];
            REG_ROW_RED:     mix_rows[0] = data;
            REG_ROW_GREEN:   mix_rows[1] = data;
            REG_ROW_BLUE:    mix_rows[2] = data;
            default: ;
        endcase
    endfunction

    // degamma values: zero, exactly one, plain range, and raw values that saturate
    function automatic logic [LIN_W-1:0] rand_lin();
        int roll;
        roll = $urandom_range(0, 9);
        case (roll)
            0:       return '0;
            1:       return DEGAMMA_ONE;
            2, 3:    return LIN_W'($urandom());
            default: return LIN_W'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic t_pix_beat random_beat(input t_cmd cmd);
        t_pix_beat b;
        b.cmd   = cmd;
        b.red   = CHAN_W'($urandom());
        b.green = CHAN_W'($urandom());
        b.blue  = CHAN_W'($urandom());
        b.last  = ($urandom_range(0, 7) == 0);
        b.tidx  = TINDEX_W'($urandom());
        b.tval  = TVALUE_W'($urandom());
        return b;
    endfunction

    function automatic logic [COEFF_W-1:0] pick_coeff(input t_row_style style, input bit diag);
        case (style)
            ROWS_IDENTITY: return diag ? COEFF_ONE : '0;
            ROWS_NEAR: begin
                // a plausible panel matrix: strong diagonal, small negative cross terms
                if (diag)
                    return COEFF_ONE + COEFF_W'($urandom_range(0, 24575));
                return COEFF_W'(0) - COEFF_W'($urandom_range(0, 8192));
            end
            ROWS_MAX:    return COEFF_MAX;
            ROWS_MIN:    return COEFF_MIN;
            ROWS_ZERO:   return '0;
            ROWS_RANDOM: return COEFF_W'($urandom());
            default: begin
                case ($urandom_range(0, 5))
                    0:       return '0;
                    1:       return COEFF_ONE;
                    2:       return COEFF_MAX;
                    3:       return COEFF_MIN;
                    4:       return '1;
                    default: return COEFF_W'($urandom());
                endcase
            end
        endcase
    endfunction

    // one beat on the stream, after a random idle unless the sender is calm
    task automatic send_beat(input t_pix_beat b, input bit typed, input t_pix_rgb want);
        int       idle;
        t_pix_rgb model_rgb;
        idle = tx_calm ? 0 : gap_len();
        if (idle != 0) begin
            pix_in.valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        pix_in.valid       <= 1'b1;
        pix_in.command     <= b.cmd;
        pix_in.red_in      <= b.red;
        pix_in.green_in    <= b.green;
        pix_in.blue_in     <= b.blue;
        pix_in.last_in     <= b.last;
        pix_in.table_index <= b.tidx;
        pix_in.table_value <= b.tval;
        @(posedge i_clk);
        while (!pix_in.ready)
            @(posedge i_clk);
        if (correct_beat(b, model_rgb))
            pending_rgb.push_back(typed ? want : model_rgb);
    endtask

    // stop sending, let every owed pixel come out, then let trailing table writes land
    task automatic settle_out();
        pix_in.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_rgb.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [ROW_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        @(posedge i_clk);
        while (!cfg.ready)
            @(posedge i_clk);
        store_reg(idx, data);
        cfg.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // output side: random stalls, with calm stretches where it always takes
    always @(posedge i_clk) begin
        if (rx_calm) begin
            pix_out.ready <= 1'b1;
            stall_left = 0;
        end else if (stall_left != 0) begin
            pix_out.ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            pix_out.ready <= 1'b1;
            stall_left = gap_len();
        end
    end

    // compare each output beat with the oldest owed pixel
    always @(posedge i_clk) begin
        t_pix_rgb want;
        t_pix_rgb seen;
        if (i_rst_n && pix_out.valid && pix_out.ready) begin
            seen = '{pix_out.red_out, pix_out.green_out, pix_out.blue_out, pix_out.last_out};
            if (pending_rgb.size() == 0) begin
                err_count++;
                $display("%0t: unexpected pixel: expected none, got r=%h g=%h b=%h last=%b",
                         $time, seen.red, seen.green, seen.blue, seen.last);
            end else begin
                want = pending_rgb.pop_front();
                if (seen.red !== want.red || seen.green !== want.green ||
                    seen.blue !== want.blue || seen.last !== want.last) begin
                    err_count++;
                    $display({"%0t: pixel mismatch: expected r=%h g=%h b=%h last=%b,",
                              " got r=%h g=%h b=%h last=%b"},
                             $time, want.red, want.green, want.blue, want.last,
                             seen.red, seen.green, seen.blue, seen.last);
                end
            end
        end
    end

    // watchdog: too long without any beat on any channel means a hang
    always @(posedge i_clk) begin
        if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready) ||
            (cfg.valid && cfg.ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d pixels still owed",
                     $time, quiet_cycles, pending_rgb.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        t_pix_beat        b;
        t_plan_row        step;
        logic [ROW_W-1:0] row;
        int               done;
        int               roll;

        i_rst_n            = 1'b0;
        pix_in.valid       = 1'b0;
        pix_in.command     = CMD_PIXEL;
        pix_in.red_in      = '0;
        pix_in.green_in    = '0;
        pix_in.blue_in     = '0;
        pix_in.last_in     = 1'b0;
        pix_in.table_index = '0;
        pix_in.table_value = '0;
        cfg.valid          = 1'b0;
        cfg.index          = REG_PASSTHROUGH;
        cfg.data           = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill both tables so no pixel ever reads an entry never written;
        // degamma indexes carry random upper bits that the block drops
        for (int i = 0; i < DG_DEPTH; i++) begin
            b      = random_beat(CMD_DEGAMMA);
            b.tidx = {6'($urandom()), 5'(i)};
            b.tval = rand_lin();
            send_beat(b, 1'b0, NO_RGB);
        end
        for (int i = 0; i < ENC_DEPTH; i++) begin
            b      = random_beat(CMD_ENCODE);
            b.tidx = TINDEX_W'(i);
            send_beat(b, 1'b0, NO_RGB);
        end

        // directed rows
        foreach (DIR_PLAN[n]) begin
            step = DIR_PLAN[n];
            if (step.kind == STEP_CFG) begin
                settle_out();
                cfg_write(step.cfg_idx, step.cfg_data);
            end else begin
                send_beat(step.beat, step.kind == STEP_TYPED, step.want);
            end
        end

        // random phases, each with its own matrix and passthrough setting;
        // every phase starts from a drained pipeline
        for (int p = 0; p < PHASES; p++) begin
            settle_out();
            tx_calm = (p % 3 == 0);
            rx_calm = (p % 4 == 0);
            // passthrough register with junk in the unused upper bits
            row    = {22'($urandom()), 32'($urandom())};
            row[0] = (p == BYPASS_PHASE);
            cfg_write(REG_PASSTHROUGH, row);
            for (int lane = 0; lane < NUM_CHAN; lane++) begin
                for (int k = 0; k < NUM_CHAN; k++)
                    row[k*COEFF_W +: COEFF_W] = pick_coeff(PHASE_STYLE[p], k == lane);
                cfg_write(t_cfg_idx'(REG_ROW_RED + lane), row);
            end

            done = 0;
            while (done < PHASE_ITEMS) begin
                roll = $urandom_range(0, 99);
                if (roll < 82) begin
                    b = random_beat(CMD_PIXEL);
                end else if (roll < 89) begin
                    b      = random_beat(CMD_DEGAMMA);
                    b.tval = rand_lin();
                end else if (roll < 96) begin
                    b = random_beat(CMD_ENCODE);
                end else begin
                    b = random_beat(CMD_UNUSED);
                end
                send_beat(b, 1'b0, NO_RGB);
                if (b.cmd != CMD_UNUSED)
                    done++;
            end
        end

        settle_out();
        repeat (PIPE_DEPTH * 4) @(posedge i_clk);

        if (pending_rgb.size() != 0)
            $display("%0t: %0d pixels never came out", $time, pending_rgb.size());
        if (err_count == 0 && pending_rgb.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/lcc_pkg.sv
rtl/lcc_ifs.sv
rtl/lcc_degamma.sv
rtl/lcc_matrix.sv
rtl/lcc_encode.sv
rtl/handheld_lcd_color_correction.sv
test/handheld_lcd_color_correction_test.sv
